// ===== rtl/icb_pkg.sv =====
// Shared constants, operation codes and the queue word type for the circle brush.
// Used by every module of the block; depends on nothing else.
package icb_pkg;
	localparam int IMG_W      = 64;
	localparam int IMG_H      = 64;
	localparam int MAX_R      = 31;
	localparam int XW         = $clog2(IMG_W);
	localparam int YW         = $clog2(IMG_H);
	localparam int ADDR_W     = XW + YW;
	localparam int PIX_DEPTH  = IMG_W * IMG_H;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] MODE_PAINT  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_STROKE = 2'd2;

	localparam logic [1:0] OP_PAINT  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_STROKE = 2'd2;

	localparam logic [2:0] ADDR_RADIUS = 3'd0;
	localparam logic [2:0] ADDR_COLOR  = 3'd4;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [8:0] x;
		logic signed [8:0] y;
	} q_word_t;
endpackage

// ===== rtl/icb_front.sv =====
// Front end of the circle brush: takes input words and classifies them by mode.
// Depends on icb_pkg; feeds icb_queue.
module icb_front import icb_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic signed [8:0] coord_x,
	input  logic signed [8:0] coord_y,
	input  logic              clearing,
	input  logic              q_full,
	output logic              push,
	output q_word_t           push_word
);
	logic keep;

	// Nothing is taken while the frame store is being cleared after reset.
	assign in_stall = clearing | q_full;

	always_comb begin
		keep = 1'b1;
		push_word.op = OP_PAINT;
		unique case (mode)
			MODE_PAINT:  push_word.op = OP_PAINT;
			MODE_READ:   push_word.op = OP_READ;
			MODE_STROKE: push_word.op = OP_STROKE;
			default:     keep = 1'b0;
		endcase
		push_word.x = coord_x;
		push_word.y = coord_y;
	end

	// The unused mode is accepted and dropped here.
	assign push = in_valid & ~in_stall & keep;
endmodule

// ===== rtl/icb_queue.sv =====
// Short first-in first-out queue between the front end and the drawing engine.
// Depends on icb_pkg.
module icb_queue import icb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_word_t push_word,
	output logic    full,
	input  logic    pop,
	output logic    q_valid,
	output q_word_t head
);
	q_word_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     cnt_q;

	assign full    = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_valid = cnt_q != '0;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/icb_back.sv =====
// Drawing engine of the circle brush: frame store, stroke state, stamp sequencer.
// Depends on icb_pkg; pops words from icb_queue.
module icb_back import icb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_word_t     head,
	output logic        pop,
	output logic        clearing,
	input  logic [4:0]  brush_radius,
	input  logic [31:0] paint_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_value
);
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_RDONE = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_LIM   = 4'd5;
	localparam logic [3:0] S_NCNT  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIX   = 4'd8;
	localparam logic [3:0] S_STEP  = 4'd9;
	localparam logic [3:0] S_DISC  = 4'd10;
	localparam logic [3:0] S_SCAN  = 4'd11;
	localparam logic [3:0] S_NEXT  = 4'd12;

	localparam logic signed [10:0] XMAX = 11'(IMG_W - 1);
	localparam logic signed [10:0] YMAX = 11'(IMG_H - 1);

	logic [31:0]       mem [PIX_DEPTH];
	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic              started_q;
	logic signed [8:0] lastx_q, lasty_q, rx_q, ry_q;
	logic [4:0]        r_q;
	logic [8:0]        step_q;
	logic signed [9:0] dx_q, dy_q;
	logic [18:0]       d2_q;
	logic [25:0]       lim_q;
	logic [12:0]       m_q;
	logic [9:0]        n_q, k_q;
	logic [3:0]        cnt_q;
	logic [9:0]        ax_q, ay_q, pdx_q, pdy_q;
	logic signed [9:0] qdx_q, qdy_q, qx_q, qy_q;
	logic [9:0]        rdx_q, rdy_q, rmx_q, rmy_q;
	logic signed [10:0] cx_q, cy_q;
	logic [XW-1:0]     x0_q, x1_q, px_q;
	logic [YW-1:0]     y1_q, py_q;
	logic [31:0]       rd_q;
	logic              rd_in_q;
	logic              out_valid_q;
	logic [31:0]       pix_q;

	logic [4:0]        r_eff;
	logic              in_img;
	logic signed [9:0] dx_n, dy_n;
	logic [25:0]       sq;
	logic [10:0]       tx, ty, sumx, sumy;
	logic              qbx, qby;
	logic signed [10:0] cxw, cyw, lox, hix, loy, hiy, ex, ey;
	logic signed [21:0] ex2, ey2;
	logic [22:0]       dist2;
	logic [9:0]        rr;
	logic              hit, we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0]       wdata;

	always_comb begin
		if (brush_radius == 5'd0) begin
			r_eff = 5'd1;
		end else if (32'(brush_radius) > MAX_R) begin
			r_eff = 5'(MAX_R);
		end else begin
			r_eff = brush_radius;
		end
	end

	assign in_img = !rx_q[8] && !ry_q[8] && (rx_q[7:0] < 8'(IMG_W)) && (ry_q[7:0] < 8'(IMG_H));
	assign dx_n = 10'(head.x) - 10'(lastx_q);
	assign dy_n = 10'(head.y) - 10'(lasty_q);
	assign sq   = m_q * m_q;

	assign tx  = {pdx_q, ax_q[9]};
	assign ty  = {pdy_q, ay_q[9]};
	assign qbx = tx >= {1'b0, n_q};
	assign qby = ty >= {1'b0, n_q};

	assign sumx = {1'b0, rmx_q} + {1'b0, rdx_q};
	assign sumy = {1'b0, rmy_q} + {1'b0, rdy_q};

	// Floor quotient plus remainder, turned into a quotient truncated toward zero.
	assign cxw = 11'(qx_q) + 11'((qx_q < 0 && rmx_q != '0) ? 1 : 0);
	assign cyw = 11'(qy_q) + 11'((qy_q < 0 && rmy_q != '0) ? 1 : 0);
	assign lox = cxw - $signed({6'b0, r_q});
	assign hix = cxw + $signed({6'b0, r_q});
	assign loy = cyw - $signed({6'b0, r_q});
	assign hiy = cyw + $signed({6'b0, r_q});

	assign ex    = $signed(11'(px_q)) - cx_q;
	assign ey    = $signed(11'(py_q)) - cy_q;
	assign ex2   = ex * ex;
	assign ey2   = ey * ey;
	assign dist2 = 23'(ex2) + 23'(ey2);
	assign rr    = r_q * r_q;
	assign hit   = dist2 <= 23'(rr);

	assign we    = (state_q == S_CLR) || (state_q == S_SCAN && hit);
	assign waddr = (state_q == S_CLR) ? clr_q : {py_q, px_q};
	assign wdata = (state_q == S_CLR) ? 32'd0 : paint_color;
	assign raddr = {ry_q[YW-1:0], rx_q[XW-1:0]};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign pop         = (state_q == S_IDLE) && q_valid;
	assign clearing    = state_q == S_CLR;
	assign out_valid   = out_valid_q;
	assign pixel_value = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			started_q   <= 1'b0;
			lastx_q     <= '0;
			lasty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(PIX_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						case (head.op)
							OP_STROKE: started_q <= 1'b0;
							OP_READ: begin
								rx_q    <= head.x;
								ry_q    <= head.y;
								state_q <= S_READ;
							end
							default: begin
								r_q     <= r_eff;
								step_q  <= 9'(r_eff) * 9'd9;
								lastx_q <= head.x;
								lasty_q <= head.y;
								rmx_q   <= '0;
								rmy_q   <= '0;
								if (!started_q) begin
									started_q <= 1'b1;
									qx_q      <= 10'(head.x);
									qy_q      <= 10'(head.y);
									n_q       <= 10'd1;
									k_q       <= 10'd1;
									state_q   <= S_DISC;
								end else begin
									qx_q    <= 10'(lastx_q);
									qy_q    <= 10'(lasty_q);
									dx_q    <= dx_n;
									dy_q    <= dy_n;
									m_q     <= '0;
									n_q     <= '0;
									state_q <= S_SQ;
								end
							end
						endcase
					end
				end
				S_READ: begin
					if (!out_valid_q) begin
						rd_in_q <= in_img;
						state_q <= S_RDONE;
					end
				end
				S_RDONE: begin
					pix_q       <= rd_in_q ? rd_q : 32'd0;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SQ: begin
					d2_q    <= 19'(dx_q * dx_q) + 19'(dy_q * dy_q);
					state_q <= S_LIM;
				end
				S_LIM: begin
					lim_q   <= 26'(d2_q) * 26'd100;
					state_q <= S_NCNT;
				end
				S_NCNT: begin
					if (sq < lim_q) begin
						m_q <= m_q + 13'(step_q);
						n_q <= n_q + 1'b1;
					end else if (n_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						ax_q    <= dx_q[9] ? 10'(-dx_q) : 10'(dx_q);
						ay_q    <= dy_q[9] ? 10'(-dy_q) : 10'(dy_q);
						pdx_q   <= '0;
						pdy_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					pdx_q <= qbx ? 10'(tx - {1'b0, n_q}) : tx[9:0];
					pdy_q <= qby ? 10'(ty - {1'b0, n_q}) : ty[9:0];
					ax_q  <= {ax_q[8:0], qbx};
					ay_q  <= {ay_q[8:0], qby};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd9) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (!dx_q[9]) begin
						qdx_q <= $signed(ax_q);
						rdx_q <= pdx_q;
					end else if (pdx_q == '0) begin
						qdx_q <= $signed(10'd0 - ax_q);
						rdx_q <= '0;
					end else begin
						qdx_q <= $signed(10'd0 - ax_q - 10'd1);
						rdx_q <= n_q - pdx_q;
					end
					if (!dy_q[9]) begin
						qdy_q <= $signed(ay_q);
						rdy_q <= pdy_q;
					end else if (pdy_q == '0) begin
						qdy_q <= $signed(10'd0 - ay_q);
						rdy_q <= '0;
					end else begin
						qdy_q <= $signed(10'd0 - ay_q - 10'd1);
						rdy_q <= n_q - pdy_q;
					end
					k_q     <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					k_q <= k_q + 1'b1;
					if (sumx >= {1'b0, n_q}) begin
						rmx_q <= 10'(sumx - {1'b0, n_q});
						qx_q  <= qx_q + qdx_q + 10'sd1;
					end else begin
						rmx_q <= sumx[9:0];
						qx_q  <= qx_q + qdx_q;
					end
					if (sumy >= {1'b0, n_q}) begin
						rmy_q <= 10'(sumy - {1'b0, n_q});
						qy_q  <= qy_q + qdy_q + 10'sd1;
					end else begin
						rmy_q <= sumy[9:0];
						qy_q  <= qy_q + qdy_q;
					end
					state_q <= S_DISC;
				end
				S_DISC: begin
					cx_q <= cxw;
					cy_q <= cyw;
					x0_q <= (lox < 0) ? '0 : lox[XW-1:0];
					px_q <= (lox < 0) ? '0 : lox[XW-1:0];
					py_q <= (loy < 0) ? '0 : loy[YW-1:0];
					x1_q <= (hix > XMAX) ? XW'(IMG_W - 1) : hix[XW-1:0];
					y1_q <= (hiy > YMAX) ? YW'(IMG_H - 1) : hiy[YW-1:0];
					if (hix < 0 || lox > XMAX || hiy < 0 || loy > YMAX) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (px_q == x1_q) begin
						px_q <= x0_q;
						if (py_q == y1_q) begin
							state_q <= S_NEXT;
						end else begin
							py_q <= py_q + 1'b1;
						end
					end else begin
						px_q <= px_q + 1'b1;
					end
				end
				S_NEXT: begin
					state_q <= (k_q == n_q) ? S_IDLE : S_STEP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/interpolated_circle_brush.sv =====
// Circle brush top level: a read word's result is registered once the output register is free;
// a new-stroke word clears the stroke state and gives no word back.
// A later paint word works out its disc count and step, then stamps each disc, one pixel per cycle;
// the first point of a stroke stamps a single disc.
// Throughput is set by the single frame-store write port; one word is worked on at a time.
// After reset the 4096-pixel frame store is swept to zero, with input stalled.
// Registers reset to radius 4 and colour all ones; stroke state resets to not started.
module interpolated_circle_brush import icb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic signed [8:0] coord_x,
	input  logic signed [8:0] coord_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       pixel_value,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [4:0]  radius_q;
	logic [31:0] color_q;
	logic        clearing, q_full, push, pop, q_valid;
	q_word_t     push_word, head;

	// The register port never waits.
	assign pready = 1'b1;

	// A register is written on the access cycle of a write; other addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 5'd4;
			color_q  <= 32'hFFFF_FFFF;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_RADIUS) begin
				radius_q <= pwdata[4:0];
			end else if (paddr == ADDR_COLOR) begin
				color_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (paddr == ADDR_RADIUS) begin
			prdata = {27'd0, radius_q};
		end else if (paddr == ADDR_COLOR) begin
			prdata = color_q;
		end else begin
			prdata = 32'd0;
		end
	end

	// The front end classifies each word and drops the unused mode.
	icb_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	// A short queue lets words arrive while a long stroke is still being drawn.
	icb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	// The engine owns the frame store and the output register, which holds a read
	// result until it is taken while the engine goes on with later words.
	icb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.clearing     (clearing),
		.brush_radius (radius_q),
		.paint_color  (color_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value)
	);
endmodule

// ===== tb/interpolated_circle_brush_tb.sv =====
// Self-checking testbench for the interpolated circle brush: directed table, then random strokes.
// Needs icb_pkg and the interpolated_circle_brush RTL; holds its own frame-store predictor.
module interpolated_circle_brush_tb;
	import icb_pkg::*;

	// Longest gap with no word moving on any port before the run is abandoned.
	// It must outlast the worst single paint word (radius 31 across the whole
	// coordinate range) and the clearing sweep after reset.
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int LONG_HOLD      = 400;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        mode;
	logic signed [8:0] coord_x;
	logic signed [8:0] coord_y;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [31:0]       pixel_value;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	interpolated_circle_brush i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_value(pixel_value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predicted state of the block: the whole frame store, the stroke flag,
	// the previous point and the two registers.
	logic [31:0] canvas [PIX_DEPTH];
	bit          stroke_live;
	int          prev_x, prev_y;
	logic [4:0]  radius_reg;
	logic [31:0] colour_reg;

	// Pixel words still owed by the block, oldest first.
	logic [31:0] pixels_owed [$];

	int  error_count;
	bit  quiet;          // set for the long hold-off and the final stretch: no random idling on either side
	bit  hold_request;   // asks the receiver for one long hold-off
	int  hold_left;
	int  burst_left;
	int  idle_cycles;

	// Directed table.  Rows with check set carry a pixel word that is obvious
	// from the picture; every other read takes its word from the predictor.
	typedef struct {
		logic [1:0]  op;
		int          x;
		int          y;
		bit          check;
		logic [31:0] pix;
	} table_row_t;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	table_row_t directed [] = '{
		// A freshly cleared frame reads back as zero, in range or not.
		'{MODE_READ,     0,    0, 1, 32'h0},
		'{MODE_READ,  -256, -256, 1, 32'h0},
		'{MODE_READ,   255,  255, 1, 32'h0},
		'{MODE_READ,    63,   63, 1, 32'h0},
		// First point of a stroke stamps a single disc of radius 4.
		'{MODE_PAINT,   10,   10, 0, 32'h0},
		'{MODE_READ,    10,   10, 1, 32'hFFFF_FFFF},
		'{MODE_READ,    14,   10, 1, 32'hFFFF_FFFF},
		'{MODE_READ,    15,   10, 1, 32'h0},
		// The same point again stamps nothing but still moves the pen.
		'{MODE_PAINT,   10,   10, 0, 32'h0},
		'{MODE_PAINT,   40,   30, 0, 32'h0},
		'{MODE_READ,    25,   20, 0, 32'h0},
		// The unused mode must be swallowed without a word back.
		'{MODE_UNUSED,   0,    0, 0, 32'h0},
		// A new stroke forgets the pen, so the next point is a lone disc.
		'{MODE_STROKE,   5,    5, 0, 32'h0},
		'{MODE_PAINT,   60,   60, 0, 32'h0},
		'{MODE_READ,    63,   60, 1, 32'hFFFF_FFFF},
		// Segments reaching far outside the image are clipped.
		'{MODE_PAINT, -256,  255, 0, 32'h0},
		'{MODE_PAINT,  255, -256, 0, 32'h0},
		'{MODE_READ,     0,   63, 0, 32'h0},
		'{MODE_READ,    -1,    0, 1, 32'h0},
		'{MODE_READ,    64,    0, 1, 32'h0},
		'{MODE_READ,     0,   64, 1, 32'h0},
		'{MODE_STROKE, 255,   -1, 0, 32'h0},
		'{MODE_PAINT,    0,    0, 0, 32'h0},
		'{MODE_READ,     0,    0, 1, 32'hFFFF_FFFF},
		'{MODE_UNUSED, 255,   -1, 0, 32'h0}
	};

	function automatic int disc_radius();
		int r;
		r = radius_reg;
		if (r < 1)
			r = 1;
		if (r > MAX_R)
			r = MAX_R;
		return r;
	endfunction

	function automatic void stamp_disc(input int cx, input int cy, input int r);
		int x_lo, x_hi, y_lo, y_hi;
		x_lo = (cx - r < 0) ? 0 : cx - r;
		x_hi = (cx + r > IMG_W - 1) ? IMG_W - 1 : cx + r;
		y_lo = (cy - r < 0) ? 0 : cy - r;
		y_hi = (cy + r > IMG_H - 1) ? IMG_H - 1 : cy + r;
		for (int py = y_lo; py <= y_hi; py++)
			for (int px = x_lo; px <= x_hi; px++)
				if ((px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r)
					canvas[py * IMG_W + px] = colour_reg;
	endfunction

	// Stamps the discs that one paint point lays down.  The disc count is
	// the smallest n with (9nr)^2 >= 100*dist^2, and centres are truncated
	// toward zero, which is what SystemVerilog division does.
	function automatic void paint_stroke_point(input int x, input int y);
		int     r;
		longint dx, dy, reach, pitch, n;
		r = disc_radius();
		if (!stroke_live) begin
			stamp_disc(x, y, r);
			stroke_live = 1'b1;
		end else begin
			dx    = x - prev_x;
			dy    = y - prev_y;
			reach = 100 * (dx * dx + dy * dy);
			pitch = 9 * r;
			n     = 0;
			while (n * n * pitch * pitch < reach)
				n++;
			for (longint k = 1; k <= n; k++)
				stamp_disc(int'((prev_x * n + k * dx) / n), int'((prev_y * n + k * dy) / n), r);
		end
		prev_x = x;
		prev_y = y;
	endfunction

	function automatic logic [31:0] canvas_pixel(input int x, input int y);
		if (x >= 0 && x < IMG_W && y >= 0 && y < IMG_H)
			return canvas[y * IMG_W + x];
		return 32'h0;
	endfunction

	// Updates the prediction for one accepted word.
	function automatic void absorb_word(input logic [1:0] op, input int x, input int y,
			input bit check, input logic [31:0] pix);
		case (op)
			MODE_PAINT: begin
				paint_stroke_point(x, y);
			end
			MODE_READ: begin
				pixels_owed.push_back(check ? pix : canvas_pixel(x, y));
			end
			MODE_STROKE: begin
				stroke_live = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	// Offers one word, waits until the block takes it, then predicts.
	task automatic send_word(input logic [1:0] op, input int x, input int y,
			input bit check = 1'b0, input logic [31:0] pix = 32'h0);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		coord_x  <= x[8:0];
		coord_y  <= y[8:0];
		do
			@(posedge clk);
		while (in_stall);
		absorb_word(op, x, y, check, pix);
	endtask

	// A read at a random place: since the block works on one word at a time,
	// its answer arriving means every paint ahead of it has finished.
	task automatic settle();
		send_word(MODE_READ, $urandom_range(0, 71) - 4, $urandom_range(0, 71) - 4);
		in_valid <= 1'b0;
		while (pixels_owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then idle, so that back-to-back
	// writes never drive the port twice at the same edge.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_RADIUS)
			radius_reg = data[4:0];
		else if (addr == ADDR_COLOR)
			colour_reg = data;
		@(posedge clk);
	endtask

	// Random word: mostly paint and read near the image, some new strokes,
	// the odd unused mode, and now and then a point anywhere in range.
	task automatic send_random(input bit near_only);
		int          pick, x, y;
		logic [1:0]  op;
		logic [8:0]  raw;
		pick = $urandom_range(0, 99);
		if (pick < 58)
			op = MODE_PAINT;
		else if (pick < 90)
			op = MODE_READ;
		else if (pick < 97)
			op = MODE_STROKE;
		else
			op = MODE_UNUSED;
		if (!near_only && $urandom_range(0, 9) == 0) begin
			raw = 9'($urandom_range(0, 511));
			x   = int'($signed(raw));
			raw = 9'($urandom_range(0, 511));
			y   = int'($signed(raw));
		end else begin
			x = $urandom_range(0, 79) - 8;
			y = $urandom_range(0, 79) - 8;
		end
		send_word(op, x, y);
	endtask

	// Result side: check each word taken, then choose the next stall level.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_owed.size() == 0) begin
				$error("pixel_value: expected nothing, got %h", pixel_value);
				error_count++;
			end else begin
				if (pixel_value !== pixels_owed[0]) begin
					$error("pixel_value: expected %h, got %h", pixels_owed[0], pixel_value);
					error_count++;
				end
				void'(pixels_owed.pop_front());
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = LONG_HOLD - 1;
			out_stall   <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			burst_left = $urandom_range(1, 19) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: counts cycles in which no word moves anywhere.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("interpolated_circle_brush_tb: errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		in_valid     <= 1'b0;
		mode         <= MODE_PAINT;
		coord_x      <= '0;
		coord_y      <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		error_count  = 0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		foreach (canvas[i])
			canvas[i] = 32'h0;
		stroke_live = 1'b0;
		prev_x      = 0;
		prev_y      = 0;
		radius_reg  = 5'd4;
		colour_reg  = 32'hFFFF_FFFF;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under the reset register values.
		foreach (directed[i])
			send_word(directed[i].op, directed[i].x, directed[i].y,
				directed[i].check, directed[i].pix);
		settle();

		// Zero radius behaves as radius one.
		write_reg(ADDR_RADIUS, 32'd0);
		write_reg(ADDR_COLOR, $urandom());
		repeat (20) send_random(1'b0);
		settle();

		// Largest radius with a black brush; few points, kept near the image,
		// since each disc scans nearly four thousand pixels.
		write_reg(ADDR_RADIUS, 32'd31);
		write_reg(ADDR_COLOR, 32'h0);
		repeat (8) send_random(1'b1);
		settle();

		// Only the low five bits of the radius word count.
		write_reg(ADDR_RADIUS, 32'h25);
		write_reg(ADDR_COLOR, $urandom());
		repeat (30) send_random(1'b0);
		settle();

		// Long hold-off on the result side while reads keep coming, so the
		// input queue fills and the block has to stall its input.
		write_reg(ADDR_RADIUS, $urandom_range(2, 8));
		write_reg(ADDR_COLOR, $urandom());
		hold_request = 1'b1;
		quiet        = 1'b1;
		repeat (12) send_random(1'b1);
		quiet = 1'b0;
		repeat (18) send_random(1'b0);
		settle();

		// Final stretch with no idling at all.
		write_reg(ADDR_RADIUS, 32'd3);
		write_reg(ADDR_COLOR, 32'hFFFF_FFFF);
		quiet = 1'b1;
		repeat (32) send_random(1'b0);
		in_valid <= 1'b0;

		while (pixels_owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("interpolated_circle_brush_tb: clean");
		else
			$display("interpolated_circle_brush_tb: errors");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/icb_pkg.sv
rtl/icb_front.sv
rtl/icb_queue.sv
rtl/icb_back.sv
rtl/interpolated_circle_brush.sv
tb/interpolated_circle_brush_tb.sv
